[rtl/hpl_pkg.sv]
package hpl_pkg;

  // log2 mantissa table: LogDepth segments, LogDepth+1 knots, Q16
  localparam int unsigned LogDepth = 256;
  localparam int unsigned LogIdxW  = $clog2(LogDepth);

  localparam logic [30:0] Lg2Q32 = 31'd1292913987;  // lg 2 in Q32

  localparam logic signed [31:0] K6955  = 32'sd4558029;
  localparam logic signed [31:0] K2616  = 32'sd1714422;
  localparam logic signed [31:0] K1382  = 32'sd905708;
  localparam logic signed [31:0] K449   = 32'sd2942566;
  localparam logic signed [31:0] K655   = 32'sd429261;
  localparam logic signed [31:0] K32    = 32'sd209715;
  localparam logic signed [31:0] K497   = 32'sd325714;
  localparam logic signed [31:0] K54    = 32'sd353894;
  localparam logic signed [31:0] K478   = 32'sd313262;
  localparam logic signed [31:0] K1833  = 32'sd1201275;
  localparam logic signed [31:0] K4094  = 32'sd2683044;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  localparam logic [11:0] FreqMin = 12'd150;
  localparam logic [11:0] FreqMax = 12'd1500;

  localparam logic [2:0] ModeSub  = 3'd2;
  localparam logic [2:0] ModeOpen = 3'd3;

  localparam logic [1:0] RegFreq = 2'd0;
  localparam logic [1:0] RegTx   = 2'd1;
  localparam logic [1:0] RegRx   = 2'd2;
  localparam logic [1:0] RegMode = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FREQ = 2'd1,
    ST_MODE = 2'd2
  } status_e;

  typedef struct packed {
    logic [16:0] dist_m;
    status_e     st;
  } item_t;

  typedef struct packed {
    logic [11:0]        freq;
    logic [2:0]         mode;
    logic signed [31:0] intercept;
    logic signed [23:0] slope;
    logic               busy;
  } cfg_t;

  typedef logic [16:0] log_tab_t [LogDepth+1];

  // knots of log2(1 + i/LogDepth) by bit-serial squaring, 30 fraction bits
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [19:0] acc;
    for (int i = 0; i <= LogDepth; i++) begin
      y = (64'd1 << 30) + (((64'(i)) << 30) + 64'(LogDepth / 2)) / 64'(LogDepth);
      acc = '0;
      for (int b = 0; b < 20; b++) begin
        y = (y * y) >> 30;
        acc = {acc[18:0], 1'b0};
        if (y >= (64'd2 << 30)) begin
          acc[0] = 1'b1;
          y = y >> 1;
        end
      end
      t[i] = 17'((21'(acc) + 21'd8) >> 4);
    end
    return t;
  endfunction

  localparam log_tab_t LogTab = build_log_tab();

  // Q32 product back to Q16, half away from zero
  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r = (mag + 64'd32768) >> 16;
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

  // Q16 to Q4, half away from zero
  function automatic logic signed [63:0] rnd_q4(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r = (mag + 64'd2048) >> 12;
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

[rtl/hpl_log.sv]
// Two-stage common logarithm, Q16 out. Zero is taken as one.
module hpl_log (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [20:0] x_i,
  output logic [18:0] lg_o
);
  import hpl_pkg::*;

  logic [20:0]        xn;
  logic [4:0]         e;
  logic [31:0]        m;
  logic [31:0]        fq;
  logic [LogIdxW:0]   idx;
  logic [15:0]        w;
  logic [16:0]        lo;
  logic [16:0]        hi;
  logic [16:0]        dif;
  logic [32:0]        wp;
  logic [20:0]        l2_d, l2_q;
  logic [51:0]        p;
  logic [18:0]        lg_d, lg_q;

  always_comb begin
    xn = (x_i == '0) ? 21'd1 : x_i;
    e = '0;
    for (int k = 1; k < 21; k++) begin
      if (xn[k]) e = 5'(k);
    end
    m   = 32'(xn) << (5'd31 - e);
    fq  = {m[30:0], 1'b0};
    idx = {1'b0, fq[31:32-LogIdxW]};
    w   = fq[31-LogIdxW -: 16];
    lo  = LogTab[idx];
    hi  = LogTab[idx + 1'b1];
    dif = hi - lo;
    wp  = 33'(dif) * 33'(w) + 33'd32768;
    l2_d = {e, 16'b0} + 21'(lo) + 21'(wp >> 16);
    p    = 52'(l2_q) * 52'(Lg2Q32) + 52'd2147483648;
    lg_d = 19'(p >> 32);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l2_q <= l2_d;
      lg_q <= lg_d;
    end
  end

  assign lg_o = lg_q;

endmodule

[rtl/hpl_front.sv]
// Input side: classify each distance and hold it in a two-entry queue.
module hpl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic [16:0]         s_dist_i,
  output logic                s_ready_o,
  input  hpl_pkg::cfg_t       cfg_i,
  output logic                out_valid_o,
  output hpl_pkg::item_t      out_item_o,
  input  logic                out_ready_i
);
  import hpl_pkg::*;

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  item_t       itm;

  always_comb begin
    itm.dist_m = s_dist_i;
    if (cfg_i.freq < FreqMin || cfg_i.freq > FreqMax) begin
      itm.st = ST_FREQ;
    end else if (cfg_i.mode > ModeOpen) begin
      itm.st = ST_MODE;
    end else begin
      itm.st = ST_OK;
    end
  end

  assign s_ready_o   = (cnt_q != 2'd2) && !cfg_i.busy;
  assign push        = s_valid_i && s_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= itm;
  end

endmodule

[rtl/hpl_back.sv]
// Evaluation pipeline: log (2 stages), slope multiply, add/round/saturate.
module hpl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  hpl_pkg::item_t      in_item_i,
  output logic                in_ready_o,
  input  hpl_pkg::cfg_t       cfg_i,
  output logic                out_valid_o,
  output logic [13:0]         out_loss_o,
  output logic [1:0]          out_status_o,
  input  logic                out_ready_i
);
  import hpl_pkg::*;

  logic               ce;
  logic               v1_q, v2_q, v3_q, v4_q;
  status_e            st1_q, st2_q, st3_q, st4_q;
  logic [18:0]        lg;
  logic signed [19:0] lgd;
  logic signed [63:0] prod;
  logic signed [31:0] m3_d, m3_q;
  logic signed [63:0] sum;
  logic signed [63:0] q;
  logic [13:0]        loss_d, loss_q;

  assign ce = !v4_q || out_ready_i;
  assign in_ready_o = ce;

  hpl_log u_log (
    .clk_i (clk_i),
    .en_i  (ce),
    .x_i   (21'(in_item_i.dist_m)),
    .lg_o  (lg)
  );

  always_comb begin
    lgd  = $signed({1'b0, lg}) - 20'sd196608;
    prod = 64'(cfg_i.slope) * 64'(lgd);
    m3_d = 32'(rnd_q16(prod));
    sum  = 64'(cfg_i.intercept) + 64'(m3_q);
    q    = rnd_q4(sum);
    if (st3_q != ST_OK) begin
      loss_d = '0;
    end else if (q > 64'sd8191) begin
      loss_d = 14'd8191;
    end else if (q < -64'sd4096) begin
      loss_d = 14'h3000;
    end else begin
      loss_d = q[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (ce) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      st1_q  <= in_item_i.st;
      st2_q  <= st1_q;
      st3_q  <= st2_q;
      st4_q  <= st3_q;
      m3_q   <= m3_d;
      loss_q <= loss_d;
    end
  end

  assign out_valid_o  = v4_q;
  assign out_loss_o   = loss_q;
  assign out_status_o = st4_q;

endmodule

[rtl/hpl_cfg.sv]
// Register file and coefficient sequencer. Every write reruns the
// sequence; intercept and slope are good once it reaches ST_DONE.
module hpl_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic [3:0]     paddr_i,
  input  logic [31:0]    pwdata_i,
  output logic [31:0]    prdata_o,
  output hpl_pkg::cfg_t  cfg_o
);
  import hpl_pkg::*;

  typedef enum logic [3:0] {
    ST_LG0, ST_LG1, ST_LG2, ST_LG3, ST_LG4, ST_LG5,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_DONE
  } seq_e;

  seq_e               state_q;
  logic [11:0]        freq_q, tx_q;
  logic [9:0]         rx_q;
  logic [2:0]         mode_q;
  logic signed [31:0] lf_q, lt_q, lr_q, l28_q, tmp_q, base_q;
  logic signed [23:0] slope_q;
  logic               wr;
  logic [20:0]        lx;
  logic [18:0]        lg;
  logic signed [31:0] lgs;
  logic signed [31:0] opa, opb, dl, r;

  assign wr  = psel_i && penable_i && pwrite_i;
  assign lgs = $signed({13'b0, lg});
  assign dl  = lf_q - l28_q;

  hpl_log u_log (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .x_i   (lx),
    .lg_o  (lg)
  );

  always_comb begin
    lx  = '0;
    opa = '0;
    opb = '0;
    unique case (state_q)
      ST_LG0: lx = 21'(freq_q);
      ST_LG1: lx = 21'(tx_q);
      ST_LG2: lx = 21'(11'd1175 * 21'(rx_q));
      ST_LG3: lx = 21'd28;
      ST_M1: begin opa = K32;   opb = lr_q; end
      ST_M2: begin opa = tmp_q; opb = lr_q; end
      ST_M3: begin opa = K2616; opb = lf_q; end
      ST_M4: begin opa = K1382; opb = lt_q; end
      ST_M5: begin opa = K655;  opb = lt_q; end
      ST_M6: begin
        if (mode_q == ModeSub) begin
          opa = dl;
          opb = dl;
        end else begin
          opa = K478;
          opb = lf_q;
        end
      end
      ST_M7: begin opa = tmp_q; opb = lf_q; end
      ST_M8: begin opa = K1833; opb = lf_q; end
      default: ;
    endcase
    r = 32'(rnd_q16(64'(opa) * 64'(opb)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LG0;
      freq_q  <= 12'd900;
      tx_q    <= 12'd300;
      rx_q    <= 10'd15;
      mode_q  <= 3'd1;
      lf_q    <= '0;
      lt_q    <= '0;
      lr_q    <= '0;
      l28_q   <= '0;
      tmp_q   <= '0;
      base_q  <= '0;
      slope_q <= '0;
    end else if (wr) begin
      state_q <= ST_LG0;
      unique case (paddr_i[3:2])
        RegFreq: freq_q <= pwdata_i[11:0];
        RegTx:   tx_q   <= pwdata_i[11:0];
        RegRx:   rx_q   <= pwdata_i[9:0];
        RegMode: mode_q <= pwdata_i[2:0];
      endcase
    end else begin
      unique case (state_q)
        ST_LG0: state_q <= ST_LG1;
        ST_LG1: state_q <= ST_LG2;
        ST_LG2: begin lf_q <= lgs;              state_q <= ST_LG3; end
        ST_LG3: begin lt_q <= lgs - OneQ16;     state_q <= ST_LG4; end
        ST_LG4: begin lr_q <= lgs - 3 * OneQ16; state_q <= ST_LG5; end
        ST_LG5: begin l28_q <= lgs;             state_q <= ST_M1;  end
        ST_M1: begin tmp_q <= r; state_q <= ST_M2; end
        ST_M2: begin base_q <= K6955 + K497 - r; state_q <= ST_M3; end
        ST_M3: begin base_q <= base_q + r; state_q <= ST_M4; end
        ST_M4: begin base_q <= base_q - r; state_q <= ST_M5; end
        ST_M5: begin slope_q <= 24'(K449 - r); state_q <= ST_M6; end
        ST_M6: begin tmp_q <= r; state_q <= ST_M7; end
        ST_M7: begin
          if (mode_q == ModeSub) begin
            base_q <= base_q - (tmp_q <<< 1) - K54;
          end else if (mode_q == ModeOpen) begin
            base_q <= base_q - r;
          end
          state_q <= ST_M8;
        end
        ST_M8: begin
          if (mode_q == ModeOpen) base_q <= base_q + r - K4094;
          state_q <= ST_DONE;
        end
        ST_DONE: state_q <= ST_DONE;
        default: state_q <= ST_LG0;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      RegFreq: prdata_o = 32'(freq_q);
      RegTx:   prdata_o = 32'(tx_q);
      RegRx:   prdata_o = 32'(rx_q);
      RegMode: prdata_o = 32'(mode_q);
    endcase
  end

  assign cfg_o.freq      = freq_q;
  assign cfg_o.mode      = mode_q;
  assign cfg_o.intercept = base_q;
  assign cfg_o.slope     = slope_q;
  assign cfg_o.busy      = (state_q != ST_DONE);

endmodule

[rtl/hata_path_loss.sv]
// Okumura-Hata median path loss, one distance in, one loss out.
// Input stream (s_axis): 17-bit distance in metres, one per transfer.
// Output stream (m_axis): loss in 1/16 dB (14-bit signed, saturated) and a
// status code (ok, frequency out of range, unknown environment mode).
// APB port: frequency, tx height, rx height and mode at byte offsets
// 0, 4, 8, 12; pready is tied high, reads return the register.
// Throughput: one transfer per cycle while the sequencer is idle and m_axis_tready is high.
// Each input transfer is first written into the queue. The queue head
// feeds the log unit directly; the result is registered after the log
// unit's table lookup plus interpolation, after its lg 2 scaling, after
// the slope multiply, and after the add, round and saturate into the
// output register.
// After reset and after every register write the coefficient sequencer
// runs through four shared logarithms, then eight multiply steps on one
// multiplier; s_axis_tready stays low for that time.
// When a result waits and m_axis_tready is low the back pipeline holds, the two-entry queue
// keeps taking transfers until full, then s_axis_tready drops.
module hata_path_loss (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] distance_m, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [13:0] loss_q4, [15:14] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hpl_pkg::*;

  cfg_t       cfg;
  logic       q_valid, q_ready;
  item_t      q_item;
  logic [13:0] loss;
  logic [1:0]  status;

  assign pready = 1'b1;

  hpl_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  hpl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_dist_i    (s_axis_tdata[16:0]),
    .s_ready_o   (s_axis_tready),
    .cfg_i       (cfg),
    .out_valid_o (q_valid),
    .out_item_o  (q_item),
    .out_ready_i (q_ready)
  );

  hpl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_item_i    (q_item),
    .in_ready_o   (q_ready),
    .cfg_i        (cfg),
    .out_valid_o  (m_axis_tvalid),
    .out_loss_o   (loss),
    .out_status_o (status),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {status, loss};

`ifndef SYNTHESIS
  // no distance enters while the coefficients are being recomputed
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.busy |-> !s_axis_tready) else $error("input taken during derive");

  // a register write stalls the input on the next cycle
  a_wr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> !s_axis_tready)
    else $error("input open after config write");

  // error status always comes with zero loss
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[15:14] != ST_OK) |-> m_axis_tdata[13:0] == '0)
    else $error("nonzero loss with error status");
`endif

endmodule
